@@ rtl/tkh_pkg.sv @@
// ----------------------------------------------------------------------------
// tkh_pkg
// Shared types of the tiered-key min-heap queue: operation and status codes,
// the key word and the payloads of the request and result channels.
// ----------------------------------------------------------------------------
package tkh_pkg;

    // key word {priority, arrival time, id}, compared as one unsigned number
    localparam int KEY_W = 40;
    localparam int CNT_OUT_W = 7;

    typedef logic [KEY_W-1:0] key_t;

    typedef enum logic
    {
        KIND_PUSH = 1'b0,
        KIND_POP  = 1'b1
    } kind_t;

    typedef enum logic [1:0]
    {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef struct packed
    {
        kind_t       kind;
        logic [7:0]  priority_req;
        logic [15:0] arrival_time;
        logic [15:0] entry_id;
    } req_t;

    typedef struct packed
    {
        status_t                status;
        logic                   out_valid;
        logic [7:0]             out_priority;
        logic [15:0]            out_time;
        logic [15:0]            out_id;
        logic [CNT_OUT_W-1:0]   count;
    } res_t;

endpackage

@@ rtl/tkh_chan_if.sv @@
// ----------------------------------------------------------------------------
// tkh_chan_if
// Valid/ready channel carrying one item of a chosen payload type.
// ----------------------------------------------------------------------------
interface tkh_chan_if #(parameter type payload_t = logic);

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source
    (
        output valid,
        output payload,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  payload,
        output ready
    );

endinterface

@@ rtl/tiered_key_min_heap_queue.sv @@
// ----------------------------------------------------------------------------
// tiered_key_min_heap_queue
// Binary min-heap priority queue over {priority, arrival time, id} keys.
// ----------------------------------------------------------------------------
// Usage
//   req (sink, payload tkh_pkg::req_t): one push or pop item per handshake.
//   res (source, payload tkh_pkg::res_t): exactly one result item per request,
//   in request order, with status, popped entry (pops only) and entry count.
//   The heap sits in one DEPTH x 40 bit memory with two registered read ports
//   and one write port. The entry in motion is held in a register and only
//   the displaced entries are written back, one level per cycle.
//   An entry moves at most log2(DEPTH) levels, six at depth 64. Each level
//   costs one memory read, a compare and a write; a pop first reads the
//   root and the last entry. A rejected item moves no entry.
//   Items are handled one at a time; req is ready whenever no item is in work,
//   also while a finished result still waits in the output register.
//   If res is stalled, the next item runs and then holds in its last state
//   until the output register is free.
//   Reset empties the heap (count zero) and drops any pending result; the
//   memory itself is not cleared, unwritten entries are never used.
//   A push into a full heap and a pop from an empty heap leave the heap as
//   it is and report status full or empty.
// ----------------------------------------------------------------------------
module tiered_key_min_heap_queue #(
    parameter int DEPTH = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    tkh_chan_if.sink   req,
    tkh_chan_if.source res
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = AW + 2;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_UP,
        S_POP_LD,
        S_DOWN,
        S_FIN
    } state_t;

    // left child index of a heap slot, wide enough to exceed the depth
    function automatic logic [IW-1:0] child_l(input logic [AW-1:0] h);
        child_l = {1'b0, h, 1'b1};
    endfunction

    // heap memory
    tkh_pkg::key_t mem [DEPTH];
    tkh_pkg::key_t rd_a_reg;
    tkh_pkg::key_t rd_b_reg;
    logic [AW-1:0] rd_addr_a;
    logic [AW-1:0] rd_addr_b;
    logic          mem_we;
    logic [AW-1:0] wr_addr;
    tkh_pkg::key_t wr_data;

    // control and working registers
    state_t           state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [AW-1:0]    hole_reg, hole_next;
    tkh_pkg::key_t    key_reg, key_next;
    tkh_pkg::key_t    root_reg, root_next;
    tkh_pkg::status_t status_reg, status_next;
    logic             popped_reg, popped_next;
    logic             place_reg, place_next;
    logic             res_valid_reg, res_valid_next;
    tkh_pkg::res_t    res_data_reg, res_data_next;

    // combinational helpers
    logic             req_fire;
    logic             res_free;
    tkh_pkg::key_t    in_key;
    logic [IW-1:0]    n_ext;
    logic [AW-1:0]    hole_m1;
    logic [AW-1:0]    cnt_m1;
    logic [IW-1:0]    l_cur;
    logic [IW-1:0]    r_cur;
    logic             r_ok;
    logic             left_lt;
    logic             right_lt;
    tkh_pkg::key_t    sel_val;
    logic [IW-1:0]    child_idx;
    tkh_pkg::key_t    child_val;
    logic [IW-1:0]    l_next;
    logic [CW+6:0]    cnt_wide;

    assign req_fire  = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign res_free  = !res_valid_reg || res.ready;
    assign in_key    = {req.payload.priority_req, req.payload.arrival_time,
                        req.payload.entry_id};
    assign n_ext     = IW'(count_reg);
    assign hole_m1   = hole_reg - AW'(1);
    assign cnt_m1    = count_reg[AW-1:0] - AW'(1);
    assign cnt_wide  = {7'd0, count_reg};

    // sift-down compare: smaller child, left wins a tie
    assign l_cur     = child_l(hole_reg);
    assign r_cur     = l_cur + IW'(1);
    assign r_ok      = (r_cur < n_ext);
    assign left_lt   = (rd_a_reg < key_reg);
    assign sel_val   = left_lt ? rd_a_reg : key_reg;
    assign right_lt  = r_ok && (rd_b_reg < sel_val);
    assign child_idx = right_lt ? r_cur : l_cur;
    assign child_val = right_lt ? rd_b_reg : rd_a_reg;
    assign l_next    = child_l(child_idx[AW-1:0]);

    // next-state and memory port logic
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        hole_next      = hole_reg;
        key_next       = key_reg;
        root_next      = root_reg;
        status_next    = status_reg;
        popped_next    = popped_reg;
        place_next     = place_reg;
        res_valid_next = res_valid_reg;
        res_data_next  = res_data_reg;
        rd_addr_a      = '0;
        rd_addr_b      = '0;
        mem_we         = 1'b0;
        wr_addr        = hole_reg;
        wr_data        = key_reg;

        if (res_valid_reg && res.ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    root_next   = '0;
                    popped_next = 1'b0;
                    place_next  = 1'b0;
                    status_next = tkh_pkg::STATUS_OK;
                    key_next    = in_key;
                    if (req.payload.kind == tkh_pkg::KIND_PUSH)
                    begin
                        if (count_reg == CW'(DEPTH))
                        begin
                            status_next = tkh_pkg::STATUS_FULL;
                            state_next  = S_FIN;
                        end
                        else
                        begin
                            count_next = count_reg + CW'(1);
                            hole_next  = count_reg[AW-1:0];
                            rd_addr_a  = cnt_m1 >> 1;
                            if (count_reg == '0)
                            begin
                                place_next = 1'b1;
                                state_next = S_FIN;
                            end
                            else
                            begin
                                state_next = S_UP;
                            end
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = tkh_pkg::STATUS_EMPTY;
                            state_next  = S_FIN;
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                            rd_addr_a  = '0;
                            rd_addr_b  = cnt_m1;
                            state_next = S_POP_LD;
                        end
                    end
                end
            end

            // sift up: the parent moves down into the hole while it is larger
            S_UP:
            begin
                if (key_reg < rd_a_reg)
                begin
                    mem_we    = 1'b1;
                    wr_addr   = hole_reg;
                    wr_data   = rd_a_reg;
                    hole_next = hole_m1 >> 1;
                    rd_addr_a = ((hole_m1 >> 1) - AW'(1)) >> 1;
                    if ((hole_m1 >> 1) == '0)
                    begin
                        place_next = 1'b1;
                        state_next = S_FIN;
                    end
                end
                else
                begin
                    place_next = 1'b1;
                    state_next = S_FIN;
                end
            end

            // root and last entry arrive; the last entry starts at the root
            S_POP_LD:
            begin
                root_next   = rd_a_reg;
                popped_next = 1'b1;
                key_next    = rd_b_reg;
                hole_next   = '0;
                rd_addr_a   = AW'(1);
                rd_addr_b   = AW'(2);
                if (count_reg == '0)
                begin
                    state_next = S_FIN;
                end
                else if (child_l('0) < n_ext)
                begin
                    state_next = S_DOWN;
                end
                else
                begin
                    place_next = 1'b1;
                    state_next = S_FIN;
                end
            end

            // sift down: the smaller child moves up into the hole
            S_DOWN:
            begin
                if (left_lt || right_lt)
                begin
                    mem_we    = 1'b1;
                    wr_addr   = hole_reg;
                    wr_data   = child_val;
                    hole_next = child_idx[AW-1:0];
                    rd_addr_a = l_next[AW-1:0];
                    rd_addr_b = l_next[AW-1:0] + AW'(1);
                    if (!(l_next < n_ext))
                    begin
                        place_next = 1'b1;
                        state_next = S_FIN;
                    end
                end
                else
                begin
                    place_next = 1'b1;
                    state_next = S_FIN;
                end
            end

            // park the moving entry and hand the result to the output register
            S_FIN:
            begin
                mem_we = place_reg;
                if (res_free)
                begin
                    res_valid_next             = 1'b1;
                    res_data_next.status       = status_reg;
                    res_data_next.out_valid    = popped_reg;
                    res_data_next.out_priority = root_reg[39:32];
                    res_data_next.out_time     = root_reg[31:16];
                    res_data_next.out_id       = root_reg[15:0];
                    res_data_next.count        = cnt_wide[tkh_pkg::CNT_OUT_W-1:0];
                    place_next                 = 1'b0;
                    state_next                 = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            place_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
            res_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            place_reg     <= place_next;
            res_valid_reg <= res_valid_next;
            res_data_reg  <= res_data_next;
        end
    end

    // working registers, no reset needed
    always_ff @(posedge clk)
    begin
        hole_reg     <= hole_next;
        key_reg      <= key_next;
        root_reg     <= root_next;
        status_reg   <= status_next;
        popped_reg   <= popped_next;
    end

    // heap memory, registered reads
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem[rd_addr_a];
        rd_b_reg <= mem[rd_addr_b];
    end

    assign res.valid   = res_valid_reg;
    assign res.payload = res_data_reg;

    // checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_hole_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UP || state_reg == S_DOWN) |-> (IW'(hole_reg) < n_ext))
        else $error("sift hole outside the heap");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_POP_LD) |-> !mem_we)
        else $error("memory write outside a sift");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (state_reg != S_IDLE))
        else $error("accepted item not taken into work");

    a_popped_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_data_reg.out_valid)
            |-> (res_data_reg.status == tkh_pkg::STATUS_OK))
        else $error("popped entry with failure status");

endmodule

@@ bench/tiered_key_min_heap_queue_tb.sv @@
// ----------------------------------------------------------------------------
// tiered_key_min_heap_queue_tb
// Self-checking bench for the min-heap queue. A clocked driver feeds push and
// pop items from a backlog, a clocked monitor compares every result with a
// heap kept alongside in the bench. A short directed run covers key extremes,
// tie-breaks and an empty pop. Random bursts then fill past full, drain past
// empty and mix both, under three sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module tiered_key_min_heap_queue_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HEAP_DEPTH  = 64;
    localparam int PHASE_OPS   = 230;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE      = 20;

    logic clk;
    logic rst_n;

    tkh_chan_if #(.payload_t(tkh_pkg::req_t)) req_ch ();
    tkh_chan_if #(.payload_t(tkh_pkg::res_t)) res_ch ();

    tiered_key_min_heap_queue #(
        .DEPTH (HEAP_DEPTH)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .res   (res_ch.source)
    );

    // bench copy of the heap
    tkh_pkg::key_t shadow_heap [HEAP_DEPTH];
    int unsigned   shadow_size = 0;

    tkh_pkg::req_t op_backlog [$];
    tkh_pkg::res_t predicted_outcomes [$];

    int unsigned send_idle_pct = 32;
    int unsigned recv_idle_pct = 58;
    int unsigned planned_fill  = 0;
    int unsigned ops_planned   = 0;
    int unsigned idle_cycles   = 0;
    int unsigned mismatches    = 0;
    int unsigned results_seen  = 0;
    int unsigned pushes_ok     = 0;
    int unsigned pushes_full   = 0;
    int unsigned pops_ok       = 0;
    int unsigned pops_empty    = 0;
    int unsigned deepest       = 0;

    // clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // apply one item to the bench heap and return the result it owes
    function automatic tkh_pkg::res_t heap_apply(tkh_pkg::req_t item);
        tkh_pkg::res_t r;
        tkh_pkg::key_t tmp;
        int unsigned   pos;
        int unsigned   parent;
        int unsigned   lc;
        int unsigned   rc;
        int unsigned   best;
        r = '0;
        if (item.kind == tkh_pkg::KIND_PUSH)
        begin
            if (shadow_size >= HEAP_DEPTH)
            begin
                r.status = tkh_pkg::STATUS_FULL;
                pushes_full++;
            end
            else
            begin
                pos = shadow_size;
                shadow_heap[pos] = {item.priority_req, item.arrival_time, item.entry_id};
                shadow_size++;
                pushes_ok++;
                if (shadow_size > deepest)
                    deepest = shadow_size;
                // sift up while strictly smaller than the parent
                while (pos > 0)
                begin
                    parent = (pos - 1) / 2;
                    if (!(shadow_heap[pos] < shadow_heap[parent]))
                        break;
                    tmp = shadow_heap[pos];
                    shadow_heap[pos] = shadow_heap[parent];
                    shadow_heap[parent] = tmp;
                    pos = parent;
                end
            end
        end
        else if (shadow_size == 0)
        begin
            r.status = tkh_pkg::STATUS_EMPTY;
            pops_empty++;
        end
        else
        begin
            r.status       = tkh_pkg::STATUS_OK;
            r.out_valid    = 1'b1;
            r.out_priority = shadow_heap[0][39:32];
            r.out_time     = shadow_heap[0][31:16];
            r.out_id       = shadow_heap[0][15:0];
            shadow_size--;
            pops_ok++;
            if (shadow_size > 0)
            begin
                shadow_heap[0] = shadow_heap[shadow_size];
                pos = 0;
                // sift down toward the smaller child while it is strictly smaller
                while (1)
                begin
                    lc   = 2 * pos + 1;
                    rc   = 2 * pos + 2;
                    best = pos;
                    if (lc < shadow_size && shadow_heap[lc] < shadow_heap[best])
                        best = lc;
                    if (rc < shadow_size && shadow_heap[rc] < shadow_heap[best])
                        best = rc;
                    if (best == pos)
                        break;
                    tmp = shadow_heap[pos];
                    shadow_heap[pos] = shadow_heap[best];
                    shadow_heap[best] = tmp;
                    pos = best;
                end
            end
        end
        r.count = tkh_pkg::CNT_OUT_W'(shadow_size);
        return r;
    endfunction

    // queue one item and track how full the heap will be
    function automatic void plan_op(tkh_pkg::kind_t k, logic [7:0] p, logic [15:0] t,
                                    logic [15:0] id);
        tkh_pkg::req_t item;
        item.kind         = k;
        item.priority_req = p;
        item.arrival_time = t;
        item.entry_id     = id;
        op_backlog.insert(op_backlog.size(), item);
        ops_planned++;
        if (k == tkh_pkg::KIND_PUSH && planned_fill < HEAP_DEPTH)
            planned_fill++;
        else if (k == tkh_pkg::KIND_POP && planned_fill > 0)
            planned_fill--;
    endfunction

    // random push: wide keys, heavy ties including equal keys, or field extremes
    function automatic void plan_random_push();
        int unsigned style;
        style = $urandom_range(9);
        if (style < 5)
            plan_op(tkh_pkg::KIND_PUSH, 8'($urandom), 16'($urandom), 16'($urandom));
        else if (style < 8)
            plan_op(tkh_pkg::KIND_PUSH, 8'($urandom_range(3)), 16'($urandom_range(3)),
                    16'($urandom_range(1)));
        else
            plan_op(tkh_pkg::KIND_PUSH, {8{1'($urandom)}}, {16{1'($urandom)}},
                    {16{1'($urandom)}});
    endfunction

    function automatic void plan_random_pop();
        plan_op(tkh_pkg::KIND_POP, 8'($urandom), 16'($urandom), 16'($urandom));
    endfunction

    // fill to the top and push a few more into the full heap
    function automatic void plan_fill_past_full();
        int unsigned extra;
        extra = $urandom_range(3, 1);
        while (planned_fill < HEAP_DEPTH)
            plan_random_push();
        repeat (extra)
            plan_random_push();
    endfunction

    // drain to empty and pop once or twice more
    function automatic void plan_drain_past_empty();
        int unsigned extra;
        extra = $urandom_range(2, 1);
        while (planned_fill > 0)
            plan_random_pop();
        repeat (extra)
            plan_random_pop();
    endfunction

    function automatic void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // driver: hand out backlog items, idle at random
    always @(posedge clk or negedge rst_n)
    begin : op_driver
        if (!rst_n)
        begin
            req_ch.valid   <= 1'b0;
            req_ch.payload <= '0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
                predicted_outcomes.insert(predicted_outcomes.size(),
                                          heap_apply(req_ch.payload));
            if (!req_ch.valid || req_ch.ready)
            begin
                if (op_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req_ch.valid   <= 1'b1;
                    req_ch.payload <= op_backlog.pop_front();
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: stall at random, check each result against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : result_check
        tkh_pkg::res_t want;
        tkh_pkg::res_t got;
        if (!rst_n)
        begin
            res_ch.ready <= 1'b0;
        end
        else
        begin
            res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            if (res_ch.valid && res_ch.ready)
            begin
                got = res_ch.payload;
                results_seen++;
                if (predicted_outcomes.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %0h", $time, got);
                    mismatches++;
                end
                else
                begin
                    want = predicted_outcomes.pop_front();
                    compare_field("status", want.status, got.status);
                    compare_field("out_valid", want.out_valid, got.out_valid);
                    compare_field("out_priority", want.out_priority, got.out_priority);
                    compare_field("out_time", want.out_time, got.out_time);
                    compare_field("out_id", want.out_id, got.out_id);
                    compare_field("count", want.count, got.count);
                end
            end
        end
    end

    // cycles without any handshake on either channel
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // watchdog
    initial
    begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("tiered_key_min_heap_queue test failed");
        $finish;
    end

    // stimulus
    initial
    begin : stimulus
        int unsigned phase_end;
        int unsigned burst;
        int unsigned len;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty pop, key extremes, tie-breaks on each key tier
        plan_op(tkh_pkg::KIND_POP,  8'hFF, 16'hFFFF, 16'hFFFF);
        plan_op(tkh_pkg::KIND_PUSH, 8'hFF, 16'hFFFF, 16'hFFFF);
        plan_op(tkh_pkg::KIND_PUSH, 8'h00, 16'h0000, 16'h0000);
        plan_op(tkh_pkg::KIND_PUSH, 8'h00, 16'h0000, 16'h0000);
        plan_op(tkh_pkg::KIND_PUSH, 8'h00, 16'h0000, 16'h0001);
        plan_op(tkh_pkg::KIND_PUSH, 8'h00, 16'h0001, 16'h0000);
        plan_op(tkh_pkg::KIND_PUSH, 8'h01, 16'h0000, 16'h0000);
        plan_op(tkh_pkg::KIND_PUSH, 8'h80, 16'h8000, 16'h8000);
        plan_op(tkh_pkg::KIND_PUSH, 8'h7F, 16'h7FFF, 16'h7FFF);
        repeat (8)
            plan_op(tkh_pkg::KIND_POP, 8'h00, 16'h0000, 16'h0000);
        plan_op(tkh_pkg::KIND_POP,  8'h00, 16'h0000, 16'h0000);
        plan_op(tkh_pkg::KIND_PUSH, 8'hAA, 16'h5555, 16'hAAAA);
        plan_op(tkh_pkg::KIND_PUSH, 8'h55, 16'hAAAA, 16'h5555);
        plan_op(tkh_pkg::KIND_POP,  8'h00, 16'h0000, 16'h0000);
        plan_op(tkh_pkg::KIND_POP,  8'h00, 16'h0000, 16'h0000);

        for (int phase = 0; phase < 3; phase++)
        begin
            // idling pattern of this phase
            case (phase)
                0:
                begin
                    send_idle_pct = 32;
                    recv_idle_pct = 58;
                end
                1:
                begin
                    send_idle_pct = 58;
                    recv_idle_pct = 32;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase

            // every phase passes through full and empty, then random bursts
            phase_end = ops_planned + PHASE_OPS;
            plan_fill_past_full();
            plan_drain_past_empty();
            while (ops_planned < phase_end)
            begin
                burst = $urandom_range(9);
                if (burst == 0)
                    plan_fill_past_full();
                else if (burst == 1)
                    plan_drain_past_empty();
                else
                begin
                    len = $urandom_range(40, 10);
                    repeat (len)
                    begin
                        if ($urandom_range(99) < 55)
                            plan_random_push();
                        else
                            plan_random_pop();
                    end
                end
            end

            // hold the sender until every owed result is back
            while (results_seen < ops_planned)
                @(posedge clk);
        end

        repeat (SETTLE) @(posedge clk);

        if (predicted_outcomes.size() != 0)
        begin
            $display("%0t: results missing, expected %0d more, actual 0",
                     $time, predicted_outcomes.size());
            mismatches++;
        end

        $display("covered %0d pushes (%0d into a full heap) and %0d pops (%0d on empty)",
                 pushes_ok + pushes_full, pushes_full, pops_ok + pops_empty, pops_empty);
        $display("%0d results checked, heap reached %0d entries, %0d mismatches",
                 results_seen, deepest, mismatches);
        if (mismatches == 0)
            $display("tiered_key_min_heap_queue test passed");
        else
            $display("tiered_key_min_heap_queue test failed");
        $finish;
    end

endmodule

@@ tiered_key_min_heap_queue.f @@
rtl/tkh_pkg.sv
rtl/tkh_chan_if.sv
rtl/tiered_key_min_heap_queue.sv
bench/tiered_key_min_heap_queue_tb.sv
